FILE: design/direction_to_channel_gains_defines.svh
// Assertion helpers shared by the block's checks.
`ifndef DIRECTION_TO_CHANNEL_GAINS_DEFINES_SVH
`define DIRECTION_TO_CHANNEL_GAINS_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define D2CG_CHK_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("d2cg check failed");

// next-cycle implication
`define D2CG_CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("d2cg check failed");

`endif

FILE: design/d2cg_pkg.sv
package d2cg_pkg;

  localparam int QW       = 31;  // quotient bits
  localparam int NW       = 61;  // dividend bits
  localparam int DW       = 33;  // divisor bits
  localparam int SQW      = 16;  // root bits
  localparam int DIV_LAT  = QW;  // one quotient bit per stage
  localparam int SQRT_LAT = SQW; // one root bit per stage

  typedef enum logic [1:0] {
    FMT_STEREO = 2'd0,
    FMT_QUAD   = 2'd1,
    FMT_AMBIX  = 2'd2
  } fmt_t;

  typedef struct packed {
    fmt_t fmt;
    logic xneg;
    logic xpos;
    logic yneg;
    logic zneg;
    logic rh2_zero;
    logic r2_zero;
  } side_t;

endpackage

FILE: design/direction_to_channel_gains.sv
// Channel   | Dir | Handshake            | Payload
// ----------+-----+----------------------+-----------------------------------------
// cfg       | in  | cfg_valid/cfg_ready  | cfg_data: output_format
// s_axis    | in  | tvalid/tready        | tdata: dir_x, dir_y, dir_z
// m_axis    | out | tvalid/tready        | tdata: gain_0..gain_3, channel_count
//
// One beat per cycle sustained while the output is not held. After the input,
// square and operand stages, a beat passes the divider (31 stages, one quotient
// bit each) and the square root (16 stages, one root bit each), then an 11-stage
// sine/cosine and pan section and the output register.
// rst is synchronous; it clears the valid bits and sets output_format to stereo.
// When the output beat is held, the whole pipe holds with it; input is taken
// whenever the output register is empty or being emptied.
`include "direction_to_channel_gains_defines.svh"
module direction_to_channel_gains (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] gain_0, [31:16] gain_1, [47:32] gain_2, [63:48] gain_3,
  // [66:64] channel_count, [71:67] zero
  output logic [71:0] m_axis_tdata
);

  localparam int NW       = d2cg_pkg::NW;
  localparam int DW       = d2cg_pkg::DW;
  localparam int QW       = d2cg_pkg::QW;
  localparam int SQW      = d2cg_pkg::SQW;
  localparam int LANES    = 4;
  localparam int SQ_LANES = 3;
  localparam int SD_LEN   = d2cg_pkg::DIV_LAT + d2cg_pkg::SQRT_LAT + 1;
  localparam int SQ_DLY   = d2cg_pkg::SQRT_LAT;
  localparam int TL       = 11; // trig stages P..T10

  localparam logic [30:0] ONE      = 31'h4000_0000;   // 1.0 in Q30
  localparam logic [29:0] PI4      = 30'd843314857;   // pi/4 in Q30
  localparam logic [29:0] INVSQRT2 = 30'd759250125;   // 1/sqrt2 in Q30
  localparam logic signed [15:0] GAIN_MAX  = 16'sd16384;
  localparam logic signed [15:0] GAIN_HALF = 16'sd8192;
  localparam logic [2:0] CNT_NONE   = 3'd0;
  localparam logic [2:0] CNT_STEREO = 3'd2;
  localparam logic [2:0] CNT_FULL   = 3'd4;

  // exact reciprocal multipliers for 31-bit dividends
  localparam int SH72 = 38;
  localparam int SH56 = 37;
  localparam int SH42 = 37;
  localparam int SH30 = 36;
  localparam int SH20 = 36;
  localparam int SH12 = 35;
  localparam int SH6  = 34;
  localparam logic [31:0] M72 = 32'(((64'd1 << SH72) + 64'd71) / 64'd72);
  localparam logic [31:0] M56 = 32'(((64'd1 << SH56) + 64'd55) / 64'd56);
  localparam logic [31:0] M42 = 32'(((64'd1 << SH42) + 64'd41) / 64'd42);
  localparam logic [31:0] M30 = 32'(((64'd1 << SH30) + 64'd29) / 64'd30);
  localparam logic [31:0] M20 = 32'(((64'd1 << SH20) + 64'd19) / 64'd20);
  localparam logic [31:0] M12 = 32'(((64'd1 << SH12) + 64'd11) / 64'd12);
  localparam logic [31:0] M6  = 32'(((64'd1 << SH6) + 64'd5) / 64'd6);

  // Q30 product, rounded
  function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] pr;
    pr = 62'(a) * 62'(b) + (62'd1 << 29);
    return pr[60:30];
  endfunction

  // floor(v / d) via multiplier m and shift sh
  function automatic logic [30:0] cdiv(input logic [30:0] v, input logic [31:0] m,
                                       input int sh);
    logic [62:0] pr;
    pr = 63'(v) * 63'(m);
    return 31'(pr >> sh);
  endfunction

  logic en;
  d2cg_pkg::fmt_t fmt_reg;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign cfg_ready     = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_reg <= d2cg_pkg::FMT_STEREO;
    end else if (cfg_valid && cfg_ready) begin
      fmt_reg <= d2cg_pkg::fmt_t'(cfg_data);
    end
  end

  // ---------------- valid bits ----------------
  logic v0, v1;
  logic sd_v [SD_LEN];
  logic tv   [TL];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      for (int k = 0; k < SD_LEN; k++) sd_v[k] <= 1'b0;
      for (int k = 0; k < TL; k++) tv[k] <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v0      <= s_axis_tvalid && s_axis_tready;
      v1      <= v0;
      sd_v[0] <= v1;
      for (int k = 1; k < SD_LEN; k++) sd_v[k] <= sd_v[k-1];
      tv[0]   <= sd_v[SD_LEN-1];
      for (int k = 1; k < TL; k++) tv[k] <= tv[k-1];
      m_axis_tvalid <= tv[TL-1];
    end
  end

  // ---------------- S0: input capture ----------------
  logic signed [15:0] x0, y0, z0;
  d2cg_pkg::fmt_t     f0;

  // ---------------- S1: squares ----------------
  logic signed [31:0] xx, yy, zz;
  logic signed [16:0] u0, u1;
  logic signed [33:0] uu0, uu1;
  logic [30:0]        x2_1, y2_1, z2_1;
  logic [32:0]        su0_1, su1_1;  // (x+y)^2 reaches 2^32
  logic [3:0]         upos_1;     // y-x, y+x, -x-y, x-y above zero
  d2cg_pkg::fmt_t     f1;
  logic               xneg1, xpos1, yneg1, zneg1;

  assign xx  = x0 * x0;
  assign yy  = y0 * y0;
  assign zz  = z0 * z0;
  assign u0  = y0 - x0;
  assign u1  = y0 + x0;
  assign uu0 = u0 * u0;
  assign uu1 = u1 * u1;

  // ---------------- S2: divider operands ----------------
  logic [31:0]         rh2, r2;
  logic [NW-1:0]       num_n [LANES];
  logic [DW-1:0]       den_n [LANES];
  logic [NW-1:0]       num_q [LANES];
  logic [DW-1:0]       den_q [LANES];
  logic [32:0]         su_l  [LANES];
  d2cg_pkg::side_t     sd_n;
  d2cg_pkg::side_t     sd    [SD_LEN];

  assign rh2 = 32'(x2_1) + 32'(y2_1);
  assign r2  = rh2 + 32'(z2_1);

  always_comb begin
    su_l[0] = su0_1;
    su_l[1] = su1_1;
    su_l[2] = su1_1;
    su_l[3] = su0_1;
    for (int i = 0; i < LANES; i++) begin
      num_n[i] = '0;
      den_n[i] = DW'(1);
    end
    case (f1)
      d2cg_pkg::FMT_STEREO: begin
        if (rh2 != 32'd0) begin
          num_n[0] = {x2_1, 30'd0};
          den_n[0] = DW'(rh2);
        end
      end
      d2cg_pkg::FMT_QUAD: begin
        if (rh2 != 32'd0) begin
          for (int i = 0; i < LANES; i++) begin
            den_n[i] = {rh2, 1'b0};
            if (upos_1[i]) num_n[i] = NW'({su_l[i], 14'd0}) + NW'(rh2);
          end
        end
      end
      d2cg_pkg::FMT_AMBIX: begin
        if (r2 != 32'd0) begin
          num_n[0] = {x2_1, 30'd0};
          num_n[1] = {z2_1, 30'd0};
          num_n[2] = {y2_1, 30'd0};
          for (int i = 0; i < SQ_LANES; i++) den_n[i] = DW'(r2);
        end
      end
      default: ;
    endcase
    sd_n.fmt      = f1;
    sd_n.xneg     = xneg1;
    sd_n.xpos     = xpos1;
    sd_n.yneg     = yneg1;
    sd_n.zneg     = zneg1;
    sd_n.rh2_zero = rh2 == 32'd0;
    sd_n.r2_zero  = r2 == 32'd0;
  end

  // ---------------- divider and root lanes ----------------
  logic [QW-1:0]  quo  [LANES];
  logic [SQW-1:0] root [SQ_LANES];
  logic [14:0]    qd   [SQ_DLY][LANES];  // quad gains alongside the root

  for (genvar i = 0; i < LANES; i++) begin : g_div
    d2cg_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_q[i]),
      .den (den_q[i]),
      .quo (quo[i])
    );
  end

  for (genvar i = 0; i < SQ_LANES; i++) begin : g_sqrt
    d2cg_sqrt u_sqrt (
      .clk  (clk),
      .en   (en),
      .rad  (quo[i]),
      .root (root[i])
    );
  end

  // ---------------- P: angle and non-stereo gains ----------------
  d2cg_pkg::side_t    sdl;
  logic [15:0]        mag [SQ_LANES];
  logic [3:0][15:0]   galt;
  logic [30:0]        p_next;

  assign sdl    = sd[SD_LEN-1];
  assign p_next = 31'((46'(root[0]) * 46'(PI4) + 46'd16384) >> 15);

  always_comb begin
    for (int i = 0; i < SQ_LANES; i++) mag[i] = 16'((17'(root[i]) + 17'd1) >> 1);
    galt = '0;
    case (sdl.fmt)
      d2cg_pkg::FMT_QUAD: begin
        if (sdl.rh2_zero) begin
          galt[0] = GAIN_HALF;
          galt[1] = GAIN_HALF;
        end else begin
          for (int i = 0; i < LANES; i++) galt[i] = {1'b0, qd[SQ_DLY-1][i]};
        end
      end
      d2cg_pkg::FMT_AMBIX: begin
        galt[0] = GAIN_MAX;
        if (sdl.r2_zero) begin
          galt[3] = GAIN_MAX;
        end else begin
          galt[1] = sdl.xpos ? -mag[0] : mag[0];
          galt[2] = sdl.zneg ? -mag[1] : mag[1];
          galt[3] = sdl.yneg ? -mag[2] : mag[2];
        end
      end
      default: ;
    endcase
  end

  // ---------------- trig section registers ----------------
  d2cg_pkg::side_t  tside [TL];
  logic [3:0][15:0] tg    [TL];
  logic [30:0] p_0, p_1, p_2, p_3, p_4, p_5, p_6, p_7, p_8;
  logic [30:0] p2_1, p2_2, p2_3, p2_4, p2_5, p2_6;
  logic [30:0] as_2, ac_2;
  logic [30:0] ms_3, mc_3, ms_4, mc_4, ms_5, mc_5, ms_6, mc_6, ms_7, mc_7;
  logic [30:0] ts_8, cs_8, sn_9, cs_9;
  logic        pos0_10, pos1_10;
  logic [61:0] pr0_10, pr1_10;

  // T10 operands: cos -/+ signed sine
  logic [31:0] dsum, ddif;
  logic        dif_pos;
  logic [31:0] d0, d1;
  logic        d0_pos, d1_pos;

  always_comb begin
    dsum    = 32'(cs_9) + 32'(sn_9);
    ddif    = 32'(cs_9) - 32'(sn_9);
    dif_pos = cs_9 > sn_9;
    if (tside[TL-2].xneg) begin
      d0 = dsum;  d0_pos = dsum != 32'd0;
      d1 = ddif;  d1_pos = dif_pos;
    end else begin
      d0 = ddif;  d0_pos = dif_pos;
      d1 = dsum;  d1_pos = dsum != 32'd0;
    end
  end

  // ---------------- output select ----------------
  logic [71:0] out_next;
  logic [16:0] pan0_raw, pan1_raw;
  logic [15:0] pan0, pan1;

  assign pan0_raw = 17'((pr0_10 + (62'd1 << 45)) >> 46);
  assign pan1_raw = 17'((pr1_10 + (62'd1 << 45)) >> 46);

  always_comb begin
    pan0 = !pos0_10 ? 16'd0 :
           (pan0_raw > 17'(GAIN_MAX)) ? GAIN_MAX : pan0_raw[15:0];
    pan1 = !pos1_10 ? 16'd0 :
           (pan1_raw > 17'(GAIN_MAX)) ? GAIN_MAX : pan1_raw[15:0];
    case (tside[TL-1].fmt)
      d2cg_pkg::FMT_STEREO:
        out_next = {5'd0, CNT_STEREO, 16'd0, 16'd0, pan1, pan0};
      d2cg_pkg::FMT_QUAD, d2cg_pkg::FMT_AMBIX:
        out_next = {5'd0, CNT_FULL, tg[TL-1][3], tg[TL-1][2], tg[TL-1][1], tg[TL-1][0]};
      default:
        out_next = {5'd0, CNT_NONE, 64'd0};  // reserved format marks an error
    endcase
  end

  // ---------------- payload pipeline ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      // S0
      x0 <= s_axis_tdata[15:0];
      y0 <= s_axis_tdata[31:16];
      z0 <= s_axis_tdata[47:32];
      f0 <= fmt_reg;
      // S1
      x2_1      <= xx[30:0];
      y2_1      <= yy[30:0];
      z2_1      <= zz[30:0];
      su0_1     <= uu0[32:0];
      su1_1     <= uu1[32:0];
      upos_1[0] <= !u0[16] && (u0 != 17'sd0);
      upos_1[1] <= !u1[16] && (u1 != 17'sd0);
      upos_1[2] <= u1[16];
      upos_1[3] <= u0[16];
      f1        <= f0;
      xneg1     <= x0[15];
      xpos1     <= !x0[15] && (x0 != 16'sd0);
      yneg1     <= y0[15];
      zneg1     <= z0[15];
      // S2 and the side line
      for (int i = 0; i < LANES; i++) begin
        num_q[i] <= num_n[i];
        den_q[i] <= den_n[i];
      end
      sd[0] <= sd_n;
      for (int k = 1; k < SD_LEN; k++) sd[k] <= sd[k-1];
      for (int i = 0; i < LANES; i++) qd[0][i] <= quo[i][14:0];
      for (int k = 1; k < SQ_DLY; k++) qd[k] <= qd[k-1];
      // P
      p_0      <= p_next;
      tside[0] <= sdl;
      tg[0]    <= galt;
      for (int k = 1; k < TL; k++) begin
        tside[k] <= tside[k-1];
        tg[k]    <= tg[k-1];
      end
      // T1
      p_1  <= p_0;
      p2_1 <= mulq(p_0, p_0);
      // T2: first Horner divides
      p_2  <= p_1;
      p2_2 <= p2_1;
      as_2 <= cdiv(p2_1, M72, SH72);
      ac_2 <= cdiv(p2_1, M56, SH56);
      // T3
      p_3  <= p_2;
      p2_3 <= p2_2;
      ms_3 <= mulq(p2_2, ONE - as_2);
      mc_3 <= mulq(p2_2, ONE - ac_2);
      // T4
      p_4  <= p_3;
      p2_4 <= p2_3;
      ms_4 <= cdiv(ms_3, M42, SH42);
      mc_4 <= cdiv(mc_3, M30, SH30);
      // T5
      p_5  <= p_4;
      p2_5 <= p2_4;
      ms_5 <= mulq(p2_4, ONE - ms_4);
      mc_5 <= mulq(p2_4, ONE - mc_4);
      // T6
      p_6  <= p_5;
      p2_6 <= p2_5;
      ms_6 <= cdiv(ms_5, M20, SH20);
      mc_6 <= cdiv(mc_5, M12, SH12);
      // T7
      p_7  <= p_6;
      ms_7 <= mulq(p2_6, ONE - ms_6);
      mc_7 <= mulq(p2_6, ONE - mc_6);
      // T8
      p_8  <= p_7;
      ts_8 <= ONE - cdiv(ms_7, M6, SH6);
      cs_8 <= ONE - (mc_7 >> 1);
      // T9
      sn_9 <= mulq(p_8, ts_8);
      cs_9 <= cs_8;
      // T10: scale by 1/sqrt2
      pos0_10 <= d0_pos;
      pos1_10 <= d1_pos;
      pr0_10  <= 62'(d0) * 62'(INVSQRT2);
      pr1_10  <= 62'(d1) * 62'(INVSQRT2);
      // output
      m_axis_tdata <= out_next;
    end
  end

  // ---------------- checks ----------------
  logic signed [15:0] out_g [LANES];
  logic               gain_ok;
  logic [2:0]         out_cnt;
  logic [31:0]        out_tail;
  logic [63:0]        out_gains;

  assign out_cnt   = m_axis_tdata[66:64];
  assign out_tail  = m_axis_tdata[63:32];
  assign out_gains = m_axis_tdata[63:0];

  always_comb begin
    gain_ok = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      out_g[i] = m_axis_tdata[16*i +: 16];
      if (out_g[i] > GAIN_MAX || out_g[i] < -GAIN_MAX) gain_ok = 1'b0;
    end
  end

  `D2CG_CHK_NEXT(a_beat_enters, s_axis_tvalid && s_axis_tready, v0)
  `D2CG_CHK_IMP(a_gain_range, m_axis_tvalid, gain_ok)
  `D2CG_CHK_IMP(a_stereo_tail_zero, m_axis_tvalid && out_cnt == CNT_STEREO, out_tail == 32'd0)
  `D2CG_CHK_IMP(a_reserved_zero, m_axis_tvalid && out_cnt == CNT_NONE, out_gains == 64'd0)

endmodule

FILE: design/d2cg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees num / den < 2^QW and den != 0.
module d2cg_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [d2cg_pkg::NW-1:0] num,
  input  logic [d2cg_pkg::DW-1:0] den,
  output logic [d2cg_pkg::QW-1:0] quo
);

  localparam int QW = d2cg_pkg::QW;
  localparam int NW = d2cg_pkg::NW;
  localparam int DW = d2cg_pkg::DW;
  localparam int RW = DW + 1;

  logic [RW-1:0] rem_q [QW];
  logic [QW-1:0] nlo_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  logic [RW-1:0] rem_next [QW];
  logic [QW-1:0] nlo_next [QW];
  logic [QW-1:0] quo_next [QW];

  always_comb begin
    logic [RW-1:0] rin;
    logic [RW-1:0] sh;
    logic [QW-1:0] nin;
    logic [QW-1:0] qin;
    logic [DW-1:0] din;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rin = RW'(num[NW-1:QW]);
        nin = num[QW-1:0];
        qin = '0;
        din = den;
      end else begin
        rin = rem_q[k-1];
        nin = nlo_q[k-1];
        qin = quo_q[k-1];
        din = den_q[k-1];
      end
      sh          = {rin[RW-2:0], nin[QW-1]};
      ge          = sh >= RW'(din);
      rem_next[k] = ge ? sh - RW'(din) : sh;
      nlo_next[k] = {nin[QW-2:0], 1'b0};
      quo_next[k] = {qin[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_next[k];
        nlo_q[k] <= nlo_next[k];
        quo_q[k] <= quo_next[k];
        den_q[k] <= (k == 0) ? den : den_q[k-1];
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

FILE: design/d2cg_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module d2cg_sqrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [d2cg_pkg::QW-1:0]  rad,
  output logic [d2cg_pkg::SQW-1:0] root
);

  localparam int SQW = d2cg_pkg::SQW;
  localparam int VW  = 2 * SQW;
  localparam int RW  = SQW + 3;

  logic [VW-1:0]  val_q  [SQW];
  logic [RW-1:0]  rem_q  [SQW];
  logic [SQW-1:0] root_q [SQW];

  logic [VW-1:0]  val_next  [SQW];
  logic [RW-1:0]  rem_next  [SQW];
  logic [SQW-1:0] root_next [SQW];

  always_comb begin
    logic [VW-1:0]  vin;
    logic [RW-1:0]  rin;
    logic [RW-1:0]  sh;
    logic [RW-1:0]  trial;
    logic [SQW-1:0] oin;
    logic           ge;
    for (int k = 0; k < SQW; k++) begin
      if (k == 0) begin
        vin = VW'(rad);
        rin = '0;
        oin = '0;
      end else begin
        vin = val_q[k-1];
        rin = rem_q[k-1];
        oin = root_q[k-1];
      end
      sh           = {rin[RW-3:0], vin[VW-1:VW-2]};
      trial        = RW'({oin, 2'b01});
      ge           = sh >= trial;
      rem_next[k]  = ge ? sh - trial : sh;
      root_next[k] = {oin[SQW-2:0], ge};
      val_next[k]  = {vin[VW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQW; k++) begin
        val_q[k]  <= val_next[k];
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
      end
    end
  end

  assign root = root_q[SQW-1];

endmodule
